// ----- rtl/d2q9_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and fixed-point helpers for the D2Q9 collision core.
package d2q9_pkg;

    localparam int DW  = 32;
    localparam int FB  = 28;
    localparam int RRW = FB + 2;
    localparam int ISW = FB + 1;
    localparam int MW  = DW + 3;
    localparam int XW  = 72;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = DW'(64'sd1 <<< FB);

    localparam logic [RRW-1:0]        RELAX_RST = RRW'(479349029);
    localparam logic signed [ISW-1:0] INLET_RST = ISW'(26843546);

    localparam logic [0:0] CFG_RELAX = 1'b0;
    localparam logic [0:0] CFG_INLET = 1'b1;

    typedef enum logic [1:0] {
        WK_REST = 2'd0,
        WK_AXIS = 2'd1,
        WK_DIAG = 2'd2
    } t_wkind;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic dpos;
        logic zero;
    } t_vflag;

    localparam int     DIR_CX [0:8] = '{0, 0, 0, 1, -1, 1, 1, -1, -1};
    localparam int     DIR_CY [0:8] = '{0, 1, -1, 0, 0, 1, -1, 1, -1};
    localparam t_wkind DIR_WK [0:8] = '{WK_REST, WK_AXIS, WK_AXIS, WK_AXIS, WK_AXIS,
                                        WK_DIAG, WK_DIAG, WK_DIAG, WK_DIAG};

    function automatic logic signed [DW-1:0] f_sat(input logic signed [XW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > XW'(SMAX)) begin
            r = SMAX;
        end else if (v < XW'(SMIN)) begin
            r = SMIN;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] f_qround(input logic signed [2*DW-1:0] p);
        logic signed [XW-1:0] s;
        s = (XW'(p) + (XW'(1) <<< (FB - 1))) >>> FB;
        return f_sat(s);
    endfunction

    // eight bits of a restoring divide by nine: {quotient byte, remainder}
    function automatic logic [11:0] f_div9_byte(input logic [3:0] r_in, input logic [7:0] b);
        logic [3:0] r;
        logic [4:0] t;
        logic [7:0] q;
        r = r_in;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, b[i]};
            if (t >= 5'd9) begin
                r    = 4'(t - 5'd9);
                q[i] = 1'b1;
            end else begin
                r    = t[3:0];
            end
        end
        return {q, r};
    endfunction

    // floor(4r/9) for a remainder of nine
    function automatic logic [1:0] f_four_ninths(input logic [3:0] r);
        logic [1:0] v;
        case (r)
            4'd3, 4'd4: v = 2'd1;
            4'd5, 4'd6: v = 2'd2;
            4'd7, 4'd8: v = 2'd3;
            default:    v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/d2q9_bgk_collision_core.sv -----
`timescale 1ns / 1ps
// D2Q9 BGK collision core: top level with stream ports and configuration registers.
//
// One cell enters on the slave stream: nine Q4.28 distributions in tdata and the
// inlet flag in tuser. One result leaves on the master stream: nine relaxed
// distributions, density and the two velocities. One cell per cycle is taken and
// delivered while the receiver keeps tready high. The result passes through the
// velocity divider, which resolves one quotient bit per stage over 32 stages,
// followed by the 12-stage equilibrium lanes and the relaxation stages.
// Every stage carries a valid bit. When the receiver holds tready low with a result
// waiting, the whole pipeline holds and tready on the input side drops; nothing is
// lost or repeated. Reset clears all valid bits and loads the default relaxation
// rate and inlet speed. The configuration channel is always ready; index 0 writes
// relax_rate (unsigned Q2.28), index 1 writes inlet_speed (signed Q1.28). Write
// them only while no cell is in flight.
module d2q9_bgk_collision_core
    import d2q9_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // dist_rest, dist_north, dist_south, dist_east, dist_west, dist_northeast,
    // dist_southeast, dist_northwest, dist_southwest (32 bits each)
    input  logic [9*DW-1:0]   i_s_axis_tdata,
    // at_inlet
    input  logic [0:0]        i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // out_rest, out_north, out_south, out_east, out_west, out_northeast,
    // out_southeast, out_northwest, out_southwest, density, vel_x, vel_y
    output logic [12*DW-1:0]  o_m_axis_tdata,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [0:0]        i_cfg_index,
    input  logic [RRW-1:0]    i_cfg_data
);

    localparam int DIV_LAT = DW + 2;
    localparam int EQ_LAT  = 12;
    localparam int RX_LAT  = 2;
    localparam int LAST    = 2 + DIV_LAT + EQ_LAT + RX_LAT;

    logic en;

    logic [RRW-1:0]        r_relax_rate;
    logic signed [ISW-1:0] r_inlet_speed;

    logic [LAST:0] r_vld;

    logic signed [DW-1:0] r_f0 [0:8];
    logic                 r_inl0;
    logic signed [DW-1:0] r_f1 [0:8];
    logic signed [DW-1:0] r_dens1;
    logic signed [MW-1:0] r_mx1;
    logic signed [MW-1:0] r_my1;
    logic signed [XW-1:0] n_sum;

    logic [9*DW-1:0]      w_f1_flat;
    logic [9*DW-1:0]      w_fq_flat;
    logic signed [DW-1:0] w_ux;
    logic signed [DW-1:0] w_uy;
    logic signed [DW-1:0] w_dens;
    logic signed [DW-1:0] w_omu;
    logic signed [DW-1:0] w_u0;
    logic signed [DW-1:0] w_omu0;
    logic signed [DW-1:0] w_feq  [0:8];
    logic signed [DW-1:0] w_res  [0:8];
    logic signed [DW-1:0] w_feqi [3:8];
    logic [6*DW-1:0]      w_feqi_flat;
    logic [6*DW-1:0]      w_feqi_q;
    logic [3*DW-1:0]      w_mac_q;
    logic [0:0]           w_inl_q;
    logic [12*DW-1:0]     n_out;
    logic [12*DW-1:0]     r_out;

    assign en              = !r_vld[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax_rate  <= RELAX_RST;
            r_inlet_speed <= INLET_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RELAX: r_relax_rate  <= i_cfg_data;
                CFG_INLET: r_inlet_speed <= $signed(i_cfg_data[ISW-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        n_sum = '0;
        for (int d = 0; d < 9; d++) begin
            n_sum        = n_sum + XW'(r_f0[d]);
            w_f1_flat[d*DW +: DW] = r_f1[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < 9; d++) begin
                r_f0[d] <= $signed(i_s_axis_tdata[d*DW +: DW]);
                r_f1[d] <= r_f0[d];
            end
            r_inl0  <= i_s_axis_tuser[0];
            r_dens1 <= f_sat(n_sum);
            r_mx1   <= MW'(r_f0[3]) - MW'(r_f0[4]) + MW'(r_f0[5]) + MW'(r_f0[6])
                     - MW'(r_f0[7]) - MW'(r_f0[8]);
            r_my1   <= MW'(r_f0[1]) - MW'(r_f0[2]) + MW'(r_f0[5]) - MW'(r_f0[6])
                     + MW'(r_f0[7]) - MW'(r_f0[8]);
        end
    end

    d2q9_vdiv u_vdiv_x (
        .i_clk (i_clk), .i_en (en), .i_mom (r_mx1), .i_den (r_dens1), .o_vel (w_ux)
    );

    d2q9_vdiv u_vdiv_y (
        .i_clk (i_clk), .i_en (en), .i_mom (r_my1), .i_den (r_dens1), .o_vel (w_uy)
    );

    d2q9_delay #(.WIDTH(DW), .DEPTH(DIV_LAT)) u_dly_dens (
        .i_clk (i_clk), .i_en (en), .i_d (r_dens1), .o_q (w_dens)
    );

    d2q9_omu u_omu (
        .i_clk (i_clk), .i_en (en), .i_ux (w_ux), .i_uy (w_uy), .o_omu (w_omu)
    );

    assign w_u0 = DW'(r_inlet_speed);

    d2q9_omu u_omu_inlet (
        .i_clk (i_clk), .i_en (en), .i_ux (w_u0), .i_uy ('0), .o_omu (w_omu0)
    );

    d2q9_delay #(.WIDTH(9*DW), .DEPTH(DIV_LAT + EQ_LAT)) u_dly_f (
        .i_clk (i_clk), .i_en (en), .i_d (w_f1_flat), .o_q (w_fq_flat)
    );

    for (genvar d = 0; d < 9; d++) begin : g_dir
        d2q9_equil #(.CX(DIR_CX[d]), .CY(DIR_CY[d]), .WK(DIR_WK[d])) u_equil (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dens (w_dens),
            .i_ux   (w_ux),
            .i_uy   (w_uy),
            .i_omu  (w_omu),
            .o_feq  (w_feq[d])
        );

        d2q9_relax u_relax (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_f     ($signed(w_fq_flat[d*DW +: DW])),
            .i_feq   (w_feq[d]),
            .i_omega (r_relax_rate),
            .o_res   (w_res[d])
        );
    end

    for (genvar d = 3; d < 9; d++) begin : g_inlet
        d2q9_equil #(.CX(DIR_CX[d]), .CY(DIR_CY[d]), .WK(DIR_WK[d])) u_equil (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dens (ONE),
            .i_ux   (w_u0),
            .i_uy   ('0),
            .i_omu  (w_omu0),
            .o_feq  (w_feqi[d])
        );
        assign w_feqi_flat[(d-3)*DW +: DW] = w_feqi[d];
    end

    d2q9_delay #(.WIDTH(6*DW), .DEPTH(RX_LAT)) u_dly_feqi (
        .i_clk (i_clk), .i_en (en), .i_d (w_feqi_flat), .o_q (w_feqi_q)
    );

    d2q9_delay #(.WIDTH(3*DW), .DEPTH(EQ_LAT + RX_LAT)) u_dly_mac (
        .i_clk (i_clk), .i_en (en), .i_d ({w_uy, w_ux, w_dens}), .o_q (w_mac_q)
    );

    d2q9_delay #(.WIDTH(1), .DEPTH(LAST - 1)) u_dly_inl (
        .i_clk (i_clk), .i_en (en), .i_d (r_inl0), .o_q (w_inl_q)
    );

    always_comb begin
        for (int d = 0; d < 9; d++) begin
            n_out[d*DW +: DW] = w_res[d];
        end
        if (w_inl_q[0]) begin
            for (int d = 3; d < 9; d++) begin
                n_out[d*DW +: DW] = w_feqi_q[(d-3)*DW +: DW];
            end
        end
        n_out[9*DW +: 3*DW] = w_mac_q;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> (r_vld == '0))
        else $error("valid pipeline not cleared by reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid pipeline moved during stall");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_vld[0] == $past(i_s_axis_tvalid)))
        else $error("input transfer not captured");

    a_vel_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ($signed(o_m_axis_tdata[10*DW-1:9*DW]) <= 0)) |->
        (($signed(o_m_axis_tdata[11*DW-1:10*DW]) == SMAX)
         || ($signed(o_m_axis_tdata[11*DW-1:10*DW]) == SMIN)
         || (o_m_axis_tdata[11*DW-1:10*DW] == '0)))
        else $error("velocity not saturated for nonpositive density");

endmodule

// ----- rtl/d2q9_delay.sv -----
`timescale 1ns / 1ps
// Enabled shift-register delay line for payload alignment.
module d2q9_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sr [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

// ----- rtl/d2q9_vdiv.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: velocity = (momentum << FB) / density, saturated.
module d2q9_vdiv
    import d2q9_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [MW-1:0] i_mom,
    input  logic signed [DW-1:0] i_den,
    output logic signed [DW-1:0] o_vel
);

    localparam int QW = DW;

    logic [MW-1:0] w_mag;
    logic [DW-1:0] w_hi;
    t_vflag        w_flg;

    logic [DW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [DW-1:0] r_low [0:QW];
    logic [DW-1:0] r_quo [0:QW];
    t_vflag        r_flg [0:QW];

    logic [DW-1:0] n_rem [1:QW];
    logic [DW-1:0] n_quo [1:QW];
    logic [DW-1:0] w_t   [1:QW];
    logic signed [DW:0] w_negq;
    logic signed [DW-1:0] n_vel;
    logic signed [DW-1:0] r_vel;

    always_comb begin
        w_mag      = i_mom[MW-1] ? MW'(-i_mom) : MW'(i_mom);
        w_hi       = DW'(w_mag >> (DW - FB));
        w_flg.neg  = i_mom[MW-1];
        w_flg.zero = (i_mom == '0);
        w_flg.dpos = !i_den[DW-1] && (i_den != '0);
        w_flg.ovf  = (w_hi >= DW'(i_den));
    end

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            w_t[k] = {r_rem[k-1][DW-2:0], r_low[k-1][DW-1]};
            if (w_t[k] >= r_den[k-1]) begin
                n_rem[k] = w_t[k] - r_den[k-1];
                n_quo[k] = {r_quo[k-1][DW-2:0], 1'b1};
            end else begin
                n_rem[k] = w_t[k];
                n_quo[k] = {r_quo[k-1][DW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_negq = -$signed({1'b0, r_quo[QW]});
        if (!r_flg[QW].dpos) begin
            n_vel = r_flg[QW].neg ? SMIN : (r_flg[QW].zero ? '0 : SMAX);
        end else if (r_flg[QW].ovf) begin
            n_vel = r_flg[QW].neg ? SMIN : SMAX;
        end else if (r_flg[QW].neg) begin
            n_vel = (r_quo[QW] > DW'(SMIN)) ? SMIN : w_negq[DW-1:0];
        end else begin
            n_vel = r_quo[QW][DW-1] ? SMAX : $signed(r_quo[QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi;
            r_den[0] <= DW'(i_den);
            r_low[0] <= {w_mag[DW-FB-1:0], {FB{1'b0}}};
            r_quo[0] <= '0;
            r_flg[0] <= w_flg;
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
                r_low[k] <= {r_low[k-1][DW-2:0], 1'b0};
                r_quo[k] <= n_quo[k];
                r_flg[k] <= r_flg[k-1];
            end
            r_vel <= n_vel;
        end
    end

    assign o_vel = r_vel;

endmodule

// ----- rtl/d2q9_omu.sv -----
`timescale 1ns / 1ps
// Three-stage pipeline for 1 - 1.5|u|^2.
module d2q9_omu
    import d2q9_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_ux,
    input  logic signed [DW-1:0] i_uy,
    output logic signed [DW-1:0] o_omu
);

    logic signed [2*DW-1:0] r_pxx;
    logic signed [2*DW-1:0] r_pyy;
    logic signed [DW-1:0]   r_u2;
    logic signed [DW-1:0]   r_omu;
    logic signed [DW-1:0]   n_u2;
    logic signed [DW-1:0]   n_t;
    logic signed [DW-1:0]   n_omu;

    always_comb begin
        n_u2  = f_sat(XW'(f_qround(r_pxx)) + XW'(f_qround(r_pyy)));
        n_t   = f_sat((XW'(r_u2) * XW'(3) + XW'(1)) >>> 1);
        n_omu = f_sat(XW'(ONE) - XW'(n_t));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxx <= (2*DW)'(i_ux) * (2*DW)'(i_ux);
            r_pyy <= (2*DW)'(i_uy) * (2*DW)'(i_uy);
            r_u2  <= n_u2;
            r_omu <= n_omu;
        end
    end

    assign o_omu = r_omu;

endmodule

// ----- rtl/d2q9_equil.sv -----
`timescale 1ns / 1ps
// Twelve-stage equilibrium lane for one lattice direction.
module d2q9_equil
    import d2q9_pkg::*;
#(
    parameter int     CX = 1,
    parameter int     CY = 0,
    parameter t_wkind WK = WK_AXIS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_dens,
    input  logic signed [DW-1:0] i_ux,
    input  logic signed [DW-1:0] i_uy,
    input  logic signed [DW-1:0] i_omu,
    output logic signed [DW-1:0] o_feq
);

    localparam int NX = 40;
    localparam int NB = NX / 8;
    localparam int VW = NX + 2;

    logic signed [XW-1:0]   n_cx;
    logic signed [XW-1:0]   n_cy;
    logic signed [DW-1:0]   r_cu1, r_cu2, r_cu3;
    logic signed [DW-1:0]   r_dens1, r_dens2, r_dens3, r_dens4;
    logic signed [2*DW-1:0] r_pcc;
    logic signed [DW-1:0]   n_q;
    logic signed [DW-1:0]   r_sq;
    logic signed [DW-1:0]   r_b;
    logic signed [2*DW-1:0] r_p;
    logic signed [DW-1:0]   n_t;
    logic signed [DW:0]     n_t33;
    logic [DW:0]            n_mag;
    logic [NX-1:0]          n_x;

    logic [NX-1:0] r_dx [0:NB];
    logic [NX-1:0] r_dq [0:NB];
    logic [3:0]    r_dr [0:NB];
    logic          r_dn [0:NB];
    logic [11:0]   n_div [0:NB-1];

    logic [VW-1:0]        n_v;
    logic signed [DW-1:0] r_feq;

    always_comb begin
        n_cx = '0;
        n_cy = '0;
        if (CX > 0) begin
            n_cx = XW'(i_ux);
        end else if (CX < 0) begin
            n_cx = -XW'(i_ux);
        end
        if (CY > 0) begin
            n_cy = XW'(i_uy);
        end else if (CY < 0) begin
            n_cy = -XW'(i_uy);
        end
    end

    always_comb begin
        n_q   = f_qround(r_pcc);
        n_t   = f_qround(r_p);
        n_t33 = (DW+1)'(n_t);
        n_mag = n_t[DW-1] ? (DW+1)'(-n_t33) : (DW+1)'(n_t33);
        case (WK)
            WK_REST: n_x = NX'(n_mag) + NX'(1);
            WK_DIAG: n_x = (NX'(n_mag) + NX'(18)) >> 2;
            default: n_x = NX'(n_mag) + NX'(4);
        endcase
        for (int j = 0; j < NB; j++) begin
            n_div[j] = f_div9_byte(r_dr[j], r_dx[j][NX-1-8*j -: 8]);
        end
        if (WK == WK_REST) begin
            n_v = {r_dq[NB], 2'b00} + VW'(f_four_ninths(r_dr[NB]));
        end else begin
            n_v = VW'(r_dq[NB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cu1   <= f_sat(n_cx + n_cy);
            r_dens1 <= i_dens;
            r_pcc   <= (2*DW)'(r_cu1) * (2*DW)'(r_cu1);
            r_cu2   <= r_cu1;
            r_dens2 <= r_dens1;
            r_sq    <= f_sat((XW'(n_q) * XW'(9) + XW'(1)) >>> 1);
            r_cu3   <= r_cu2;
            r_dens3 <= r_dens2;
            r_b     <= f_sat(XW'(i_omu) + XW'(r_cu3) * XW'(3) + XW'(r_sq));
            r_dens4 <= r_dens3;
            r_p     <= (2*DW)'(r_dens4) * (2*DW)'(r_b);
            r_dx[0] <= n_x;
            r_dq[0] <= '0;
            r_dr[0] <= '0;
            r_dn[0] <= n_t[DW-1];
            for (int j = 0; j < NB; j++) begin
                r_dx[j+1] <= r_dx[j];
                r_dq[j+1] <= {r_dq[j][NX-9:0], n_div[j][11:4]};
                r_dr[j+1] <= n_div[j][3:0];
                r_dn[j+1] <= r_dn[j];
            end
            r_feq <= f_sat(r_dn[NB] ? -$signed(XW'(n_v)) : $signed(XW'(n_v)));
        end
    end

    assign o_feq = r_feq;

endmodule

// ----- rtl/d2q9_relax.sv -----
`timescale 1ns / 1ps
// Two-stage BGK relaxation: round((1 - omega) f + omega feq).
module d2q9_relax
    import d2q9_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_f,
    input  logic signed [DW-1:0] i_feq,
    input  logic [RRW-1:0]       i_omega,
    output logic signed [DW-1:0] o_res
);

    localparam int OW = RRW + 1;
    localparam int PW = DW + OW;

    logic signed [OW-1:0] w_om;
    logic signed [OW-1:0] w_onem;
    logic signed [PW-1:0] r_pa;
    logic signed [PW-1:0] r_pb;
    logic signed [DW-1:0] r_res;

    assign w_om   = $signed({1'b0, i_omega});
    assign w_onem = OW'(ONE) - w_om;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa  <= PW'(i_f) * PW'(w_onem);
            r_pb  <= PW'(i_feq) * PW'(w_om);
            r_res <= f_sat((XW'(r_pa) + XW'(r_pb) + (XW'(1) <<< (FB - 1))) >>> FB);
        end
    end

    assign o_res = r_res;

endmodule

// ----- tb/sv/d2q9_bgk_collision_core_test.sv -----
`timescale 1ns / 1ps
// Stream testbench for the D2Q9 collision core: predicts every cell result and checks it.
module d2q9_bgk_collision_core_test
    import d2q9_pkg::*;
();

    typedef logic signed [127:0] t_wide;

    localparam int PIPE_DELAY  = 60;
    localparam int CYCLE_LIMIT = 400000;

    class cell_result_board;
        logic [RRW-1:0]    relax;
        logic [ISW-1:0]    inlet;
        logic [12*DW-1:0]  pending [$];
        int                errors;

        function new();
            relax  = RELAX_RST;
            inlet  = INLET_RST;
            errors = 0;
        endfunction

        function t_wide sat(t_wide x);
            t_wide hi;
            t_wide lo;
            hi = t_wide'(SMAX);
            lo = t_wide'(SMIN);
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        endfunction

        function t_wide rnd(t_wide x, int n);
            return sat((x + (t_wide'(1) <<< (n - 1))) >>> n);
        endfunction

        function t_wide qmul(t_wide a, t_wide b);
            return rnd(a * b, FB);
        endfunction

        function t_wide speed(t_wide mom, t_wide dens);
            t_wide m;
            t_wide q;
            if (dens <= 0) begin
                if (mom < 0) return t_wide'(SMIN);
                if (mom == 0) return 0;
                return t_wide'(SMAX);
            end
            m = (mom < 0) ? -mom : mom;
            q = (m <<< FB) / dens;
            return sat((mom < 0) ? -q : q);
        endfunction

        function t_wide kinetic_term(t_wide ux, t_wide uy);
            t_wide u2;
            t_wide t;
            u2 = sat(qmul(ux, ux) + qmul(uy, uy));
            t  = rnd(u2 * 3, 1);
            return sat(t_wide'(ONE) - t);
        endfunction

        function t_wide equilibrium(t_wide dens, t_wide ux, t_wide uy, t_wide omu, int d);
            t_wide cu;
            t_wide sq;
            t_wide b;
            t_wide t;
            t_wide x;
            t_wide den;
            t_wide q;
            cu  = sat(ux * t_wide'(DIR_CX[d]) + uy * t_wide'(DIR_CY[d]));
            sq  = rnd(qmul(cu, cu) * 9, 1);
            b   = sat(omu + cu * 3 + sq);
            t   = qmul(dens, b);
            x   = (d == 0) ? t * 4 : t;
            den = (d == 0) ? 9 : ((d < 5) ? 9 : 36);
            q   = (((x < 0) ? -x : x) + den / 2) / den;
            return sat((x < 0) ? -q : q);
        endfunction

        function void note_cell(logic [9*DW-1:0] cells, logic inlet_cell);
            t_wide             f [9];
            t_wide             sum;
            t_wide             mx;
            t_wide             my;
            t_wide             ux;
            t_wide             uy;
            t_wide             omu;
            t_wide             omega;
            t_wide             u0;
            t_wide             omu0;
            t_wide             v;
            logic [12*DW-1:0]  r;
            sum = 0;
            mx  = 0;
            my  = 0;
            for (int d = 0; d < 9; d++) begin
                f[d] = t_wide'($signed(cells[d*DW +: DW]));
                sum  = sum + f[d];
                mx   = mx + f[d] * t_wide'(DIR_CX[d]);
                my   = my + f[d] * t_wide'(DIR_CY[d]);
            end
            sum   = sat(sum);
            ux    = speed(mx, sum);
            uy    = speed(my, sum);
            omu   = kinetic_term(ux, uy);
            omega = $signed({98'b0, relax});
            u0    = t_wide'($signed(inlet));
            omu0  = kinetic_term(u0, 0);
            for (int d = 0; d < 9; d++) begin
                if (inlet_cell && d >= 3) begin
                    v = equilibrium(t_wide'(ONE), u0, 0, omu0, d);
                end else begin
                    v = rnd(f[d] * (t_wide'(ONE) - omega)
                            + equilibrium(sum, ux, uy, omu, d) * omega, FB);
                end
                r[d*DW +: DW] = v[DW-1:0];
            end
            r[9*DW +: DW]  = sum[DW-1:0];
            r[10*DW +: DW] = ux[DW-1:0];
            r[11*DW +: DW] = uy[DW-1:0];
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [12*DW-1:0] got);
            logic [12*DW-1:0] want;
            if (pending.size() == 0) begin
                report("result with no cell in flight");
            end else begin
                want = pending.pop_front();
                for (int i = 0; i < 12; i++) begin
                    if (got[i*DW +: DW] !== want[i*DW +: DW]) begin
                        report($sformatf("field %0d got %h want %h", i,
                                         got[i*DW +: DW], want[i*DW +: DW]));
                    end
                end
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // dist_rest, dist_north, dist_south, dist_east, dist_west, dist_northeast,
    // dist_southeast, dist_northwest, dist_southwest
    logic [9*DW-1:0]   i_s_axis_tdata;
    // at_inlet
    logic [0:0]        i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // out_rest .. out_southwest, density, vel_x, vel_y
    logic [12*DW-1:0]  o_m_axis_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [0:0]        i_cfg_index;
    logic [RRW-1:0]    i_cfg_data;

    cell_result_board  board = new();
    bit                calm = 1'b0;
    int                cycles = 0;

    d2q9_bgk_collision_core dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_RELAX;
        i_cfg_data      <= '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_RELAX) board.relax = i_cfg_data;
                else board.inlet = i_cfg_data[ISW-1:0];
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.note_cell(i_s_axis_tdata, i_s_axis_tuser[0]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata);
        end
    end

    // result side: random stall bursts, steady ready once calm
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    task write_reg(logic [0:0] idx, logic [RRW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task send_cell(logic [9*DW-1:0] cells, int inlet_cell);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= cells;
        i_s_axis_tuser  <= 1'(inlet_cell);
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DELAY) @(posedge i_clk);
    endtask

    function logic [9*DW-1:0] uniform_cell(logic [DW-1:0] v);
        logic [9*DW-1:0] c;
        for (int d = 0; d < 9; d++) c[d*DW +: DW] = v;
        return c;
    endfunction

    // near-equilibrium cell around unit density, perturbed by up to +-span
    function logic [9*DW-1:0] fluid_cell(int span);
        logic [9*DW-1:0]   c;
        logic signed [DW-1:0] base;
        for (int d = 0; d < 9; d++) begin
            base = (d == 0) ? 32'sd119304647 : ((d < 5) ? 32'sd29826162 : 32'sd7456540);
            c[d*DW +: DW] = base + $signed($urandom_range(0, 2 * span)) - span;
        end
        return c;
    endfunction

    function logic [9*DW-1:0] noise_cell();
        logic [9*DW-1:0] c;
        for (int d = 0; d < 9; d++) c[d*DW +: DW] = $urandom;
        return c;
    endfunction

    task directed_cells();
        logic [9*DW-1:0] c;
        for (int k = 0; k < 2; k++) begin
            send_cell(uniform_cell(32'h0), k);
            send_cell(uniform_cell(32'h7FFF_FFFF), k);
            send_cell(uniform_cell(32'h8000_0000), k);
            send_cell(fluid_cell(0), k);
            c = uniform_cell(32'h7FFF_FFFF);
            for (int d = 1; d < 9; d += 2) c[d*DW +: DW] = 32'h8000_0000;
            send_cell(c, k);
            // negative density, east momentum
            c = uniform_cell(32'hF000_0000);
            c[3*DW +: DW] = 32'h1000_0000;
            send_cell(c, k);
            // zero density with momentum in both axes
            c = '0;
            c[3*DW +: DW] = 32'h0400_0000;
            c[4*DW +: DW] = 32'hFC00_0000;
            c[1*DW +: DW] = 32'hFC00_0000;
            c[2*DW +: DW] = 32'h0400_0000;
            send_cell(c, k);
            // tiny density, huge velocity
            c = '0;
            c[3*DW +: DW] = 32'h7000_0000;
            c[4*DW +: DW] = 32'h9000_0001;
            c[7*DW +: DW] = 32'h0000_0010;
            send_cell(c, k);
            send_cell(fluid_cell(1 << 26), k);
        end
    endtask

    task random_cells(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) send_cell(fluid_cell(1 << 22), $urandom_range(0, 1));
            else if (pick < 8) send_cell(fluid_cell(1 << 27), $urandom_range(0, 1));
            else send_cell(noise_cell(), $urandom_range(0, 1));
        end
    endtask

    initial begin
        logic [RRW-1:0] relax_set [6];
        logic [RRW-1:0] inlet_set [6];
        relax_set = '{RELAX_RST, 30'h0, 30'h2000_0000, 30'h3FFF_FFFF, 30'h1000_0000, 30'h0};
        inlet_set = '{30'(INLET_RST), 30'h0, 30'h0800_0000, 30'h3FFF_FFFF,
                      30'h3800_0000, 30'h0};
        relax_set[5] = RRW'($urandom_range(0, 30'h2000_0000));
        inlet_set[5] = RRW'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                write_reg(CFG_RELAX, relax_set[p]);
                write_reg(CFG_INLET, inlet_set[p]);
            end
            if (p == 5) calm = 1'b1;
            if (p == 0 || p == 2) directed_cells();
            random_cells(100);
            drain();
        end
        if (board.pending.size() != 0) board.report("cells left without a result");
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
